// File: design/assert_macros.svh
// Assertion macros shared by the track association design.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: design/rta_pkg.sv
// Shared types and constants for the radar track association table.
// No dependencies.
package rta_pkg;
   localparam int MaxTracksDefault = 16;
   localparam int CoordWidth = 16;
   localparam int LifeWidth = 8;
   localparam int SlotWidth = 4;
   localparam int LiveWidth = 5;
   localparam logic [15:0] DistThreshReset = 16'd256;
   localparam logic [15:0] VelThreshReset = 16'd256;
   localparam logic [7:0] ValidCountReset = 8'd5;

   localparam logic [1:0] CsrDistance = 2'd0;
   localparam logic [1:0] CsrVelocity = 2'd1;
   localparam logic [1:0] CsrValidCount = 2'd2;

   localparam logic [1:0] OutcomeMatch = 2'd0;
   localparam logic [1:0] OutcomeNew = 2'd1;
   localparam logic [1:0] OutcomeDrop = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture detection, clear scan index
      logic scan_step;   // compare current slot, advance
      logic write_det;   // write detection to selected slot
      logic frame_step;  // age/compact one slot
      logic frame_init;  // start frame walk
      logic frame_fin;   // finish frame walk
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_hit;
      logic scan_end;
      logic frame_end_walk;
   } sts_type;
endpackage

// File: design/rta_ctrl.sv
// Controller state machine for the track association table.
// Depends on rta_pkg.
module rta_ctrl
   import rta_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  logic    frame_end,
   input  logic    out_busy,
   output logic    out_load,
   input  sts_type sts,
   output ctl_type ctl
);
   typedef enum logic [2:0] {IDLE, SCAN, WRITE, FINIT, FWALK, FFIN, DONE} state_type;
   state_type state_ff, state_in;
   logic fe_ff, fe_in;

   assign in_ready = (state_ff == IDLE);

   always_comb begin
      state_in = state_ff;
      fe_in = fe_ff;
      ctl = '0;
      out_load = 1'b0;
      unique case (state_ff)
         IDLE: begin
            if (in_valid) begin
               ctl.load = 1'b1;
               fe_in = frame_end;
               state_in = SCAN;
            end
         end
         SCAN: begin
            if (sts.scan_hit || sts.scan_end) begin
               state_in = WRITE;
            end else begin
               ctl.scan_step = 1'b1;
            end
         end
         WRITE: begin
            ctl.write_det = 1'b1;
            state_in = fe_ff ? FINIT : DONE;
         end
         FINIT: begin
            ctl.frame_init = 1'b1;
            state_in = FWALK;
         end
         FWALK: begin
            if (sts.frame_end_walk) begin
               state_in = FFIN;
            end else begin
               ctl.frame_step = 1'b1;
            end
         end
         FFIN: begin
            ctl.frame_fin = 1'b1;
            state_in = DONE;
         end
         DONE: begin
            if (!out_busy) begin
               out_load = 1'b1;
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         fe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fe_ff <= fe_in;
      end
   end
endmodule

// File: design/rta_dpath.sv
// Track table storage, gate compare and frame compaction datapath.
// Depends on rta_pkg.
module rta_dpath
   import rta_pkg::*;
#(
   parameter int MAX_TRACKS = MaxTracksDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  ctl_type     ctl,
   output sts_type     sts,
   input  logic [95:0] det,
   input  logic        det_fe,
   input  logic [15:0] dist_thr,
   input  logic [15:0] vel_thr,
   input  logic [7:0]  valid_cnt,
   output logic [SlotWidth-1:0] res_slot,
   output logic [1:0]  res_outcome,
   output logic        res_fe,
   output logic [15:0] res_elev,
   output logic [15:0] res_azim,
   output logic [LiveWidth-1:0] res_live
);
   localparam int IdxW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int CntW = $clog2(MAX_TRACKS + 1);

   logic [15:0] px_ff [MAX_TRACKS];
   logic [15:0] py_ff [MAX_TRACKS];
   logic [15:0] pz_ff [MAX_TRACKS];
   logic [15:0] sp_ff [MAX_TRACKS];
   logic [15:0] el_ff [MAX_TRACKS];
   logic [15:0] az_ff [MAX_TRACKS];
   logic [7:0]  life_ff [MAX_TRACKS];
   logic [MAX_TRACKS-1:0] upd_ff;
   logic [CntW-1:0] total_ff;
   logic [95:0] det_ff;
   logic fe_ff;
   logic [CntW-1:0] idx_ff, kept_ff;
   logic [1:0] outc_ff;
   logic [IdxW-1:0] slot_ff;

   logic [IdxW-1:0] ix;
   logic signed [16:0] dx, dy, dz, dv;
   logic [33:0] d2;
   logic [31:0] thr2;
   logic hit;
   logic full;

   assign ix = idx_ff[IdxW-1:0];
   assign dx = $signed({px_ff[ix][15], px_ff[ix]}) - $signed({det_ff[15], det_ff[15:0]});
   assign dy = $signed({py_ff[ix][15], py_ff[ix]}) - $signed({det_ff[31], det_ff[31:16]});
   assign dz = $signed({pz_ff[ix][15], pz_ff[ix]}) - $signed({det_ff[47], det_ff[47:32]});
   assign dv = $signed({sp_ff[ix][15], sp_ff[ix]}) - $signed({det_ff[63], det_ff[63:48]});
   assign d2 = 34'(dx * dx) + 34'(dy * dy) + 34'(dz * dz);
   assign thr2 = dist_thr * dist_thr;
   assign hit = (idx_ff < total_ff) && (d2 < {2'b0, thr2})
                && (dv < $signed({vel_thr[15], vel_thr}));
   assign full = (total_ff >= CntW'(MAX_TRACKS));

   assign sts.scan_hit = hit;
   assign sts.scan_end = (idx_ff >= total_ff);
   assign sts.frame_end_walk = (idx_ff >= total_ff);

   logic alive;
   logic [7:0] new_life;
   always_comb begin
      if (upd_ff[ix]) begin
         new_life = valid_cnt;
         alive = (valid_cnt != 8'd0);
      end else begin
         new_life = (life_ff[ix] != 8'd0) ? life_ff[ix] - 8'd1 : 8'd0;
         alive = (life_ff[ix] > 8'd1);
      end
   end

   logic [IdxW-1:0] kx, tx;
   assign kx = kept_ff[IdxW-1:0];
   assign tx = total_ff[IdxW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TRACKS; i++) begin
            px_ff[i] <= '0; py_ff[i] <= '0; pz_ff[i] <= '0;
            sp_ff[i] <= '0; el_ff[i] <= '0; az_ff[i] <= '0;
            life_ff[i] <= (i == 0) ? ValidCountReset : 8'd0;
         end
         upd_ff <= '0;
         total_ff <= CntW'(1);
         idx_ff <= '0;
         kept_ff <= '0;
         outc_ff <= OutcomeDrop;
         slot_ff <= '0;
      end else begin
         if (ctl.load) begin
            det_ff <= det;
            fe_ff <= det_fe;
            idx_ff <= '0;
         end
         if (ctl.scan_step) begin
            idx_ff <= idx_ff + CntW'(1);
         end
         if (ctl.write_det) begin
            if (hit) begin
               slot_ff <= ix;
               outc_ff <= OutcomeMatch;
            end else if (!full) begin
               slot_ff <= tx;
               outc_ff <= OutcomeNew;
            end else begin
               slot_ff <= '0;
               outc_ff <= OutcomeDrop;
            end
            if (hit || !full) begin
               px_ff[hit ? ix : tx] <= det_ff[15:0];
               py_ff[hit ? ix : tx] <= det_ff[31:16];
               pz_ff[hit ? ix : tx] <= det_ff[47:32];
               sp_ff[hit ? ix : tx] <= det_ff[63:48];
               el_ff[hit ? ix : tx] <= det_ff[79:64];
               az_ff[hit ? ix : tx] <= det_ff[95:80];
               upd_ff[hit ? ix : tx] <= 1'b1;
            end
            if (!hit && !full) begin
               life_ff[tx] <= valid_cnt;
               total_ff <= total_ff + CntW'(1);
            end
         end
         if (ctl.frame_init) begin
            idx_ff <= '0;
            kept_ff <= '0;
         end
         if (ctl.frame_step) begin
            if (alive) begin
               px_ff[kx] <= px_ff[ix]; py_ff[kx] <= py_ff[ix];
               pz_ff[kx] <= pz_ff[ix]; sp_ff[kx] <= sp_ff[ix];
               el_ff[kx] <= el_ff[ix]; az_ff[kx] <= az_ff[ix];
               life_ff[kx] <= new_life;
               kept_ff <= kept_ff + CntW'(1);
            end
            idx_ff <= idx_ff + CntW'(1);
         end
         if (ctl.frame_fin) begin
            upd_ff <= '0;
            if (kept_ff == '0) begin
               px_ff[0] <= '0; py_ff[0] <= '0; pz_ff[0] <= '0;
               sp_ff[0] <= '0; el_ff[0] <= '0; az_ff[0] <= '0;
               life_ff[0] <= valid_cnt;
               total_ff <= CntW'(1);
            end else begin
               total_ff <= kept_ff;
            end
         end
      end
   end

   assign res_slot = SlotWidth'(slot_ff);
   assign res_outcome = outc_ff;
   assign res_fe = fe_ff;
   assign res_elev = fe_ff ? el_ff[0] : 16'd0;
   assign res_azim = fe_ff ? az_ff[0] : 16'd0;
   assign res_live = LiveWidth'(total_ff);
endmodule

// File: design/radar_track_association_table.sv
// Radar track association table: gated first-match track update per detection.
// Sequence: scan slots until the first gated match or the end of the live tracks, write,
// then compact the table on frame end; a stalled result holds the next load.
// Throughput: one detection at a time, next detection accepted in the cycle after the result
// register loads; scan and compaction walk a slot a cycle.
// Synchronous active-high reset: thresholds 256/256, valid count 5, one zero track.
`include "assert_macros.svh"
module radar_track_association_table
   import rta_pkg::*;
#(
   parameter int MAX_TRACKS = MaxTracksDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // pos_x, pos_y, pos_z, radial_speed, elev_angle, azim_angle
   input  logic        req_tlast,  // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // track_slot, outcome, frame_done, aim_elevation,
                                   // aim_azimuth, live_tracks, zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   logic [15:0] dist_ff, vel_ff;
   logic [7:0] vcnt_ff;
   ctl_type ctl;
   sts_type sts;
   logic out_load;
   logic [SlotWidth-1:0] r_slot;
   logic [1:0] r_outc;
   logic r_fe;
   logic [15:0] r_el, r_az;
   logic [LiveWidth-1:0] r_live;
   logic rsp_valid_ff;
   logic [47:0] rsp_data_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= DistThreshReset;
         vel_ff <= VelThreshReset;
         vcnt_ff <= ValidCountReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            CsrDistance: dist_ff <= csr_data;
            CsrVelocity: vel_ff <= csr_data;
            CsrValidCount: vcnt_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   rta_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .frame_end(req_tlast),
      .out_busy(rsp_valid_ff && !rsp_tready), .out_load(out_load),
      .sts(sts), .ctl(ctl)
   );

   rta_dpath #(.MAX_TRACKS(MAX_TRACKS)) u_dpath (
      .clock(clock), .reset(reset), .ctl(ctl), .sts(sts),
      .det(req_tdata), .det_fe(req_tlast),
      .dist_thr(dist_ff), .vel_thr(vel_ff), .valid_cnt(vcnt_ff),
      .res_slot(r_slot), .res_outcome(r_outc), .res_fe(r_fe),
      .res_elev(r_el), .res_azim(r_az), .res_live(r_live)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_data_ff <= {4'b0, r_live, r_az, r_el, r_fe, r_outc, r_slot};
      end
   end
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   `ASSERT_NEXT(a_load_sets_valid, clock, reset, out_load, rsp_tvalid)
   `ASSERT_IMPL(a_one_cmd, clock, reset, 1'b1, $onehot0(ctl))
   `ASSERT_IMPL(a_no_accept_busy, clock, reset, !req_tready, !ctl.load)
endmodule
